// ----- hdl/hms_pkg.sv -----
// hms_pkg: item types, key codes and divide constants for the countdown timer.
// No dependencies; used by hms_ctrl, hms_split and hms_countdown_timer.
package hms_pkg;

   localparam int REM_W  = 28;   // remaining seconds
   localparam int ACC_W  = 16;   // digit accumulators
   localparam int HOUR_W = 17;

   // event kinds
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_KEY  = 1'b1;

   // key codes (ASCII)
   localparam logic [7:0] KEY_C    = 8'h63;  // 'c'
   localparam logic [7:0] KEY_ZERO = 8'h30;  // '0'
   localparam logic [7:0] KEY_NINE = 8'h39;  // '9'
   localparam logic [7:0] KEY_PLUS = 8'h2B;  // '+'

   localparam logic [REM_W-1:0] SECS_PER_HOUR = 28'd3600;
   localparam logic [REM_W-1:0] SECS_PER_MIN  = 28'd60;

   // x/3600 = (x>>4)/225; 24-bit dividend, reciprocal ceil(2^32/225), shift 32
   localparam logic [24:0] HOUR_RECIP = 25'd19088744;
   // r/60 = (r>>2)/15 for r < 3600; 10-bit dividend, ceil(2^14/15), shift 14
   localparam logic [10:0] MIN_RECIP  = 11'd1093;

   typedef struct packed {
      logic       func;
      logic [7:0] key_code;
   } req_type;

   typedef struct packed {
      logic [REM_W-1:0]  remaining_seconds;
      logic [HOUR_W-1:0] hours;
      logic [5:0]        minutes;
      logic [5:0]        seconds;
      logic [1:0]        phase_now;
      logic              counting;
      logic              paused_led;
      logic              expired_led;
   } rsp_type;

   // timer state after an item, handed from control to the split pipeline
   typedef struct packed {
      logic [REM_W-1:0] remaining;
      logic [1:0]       phase;
      logic             running;
      logic             paused;
      logic             expired;
   } status_type;

endpackage

// ----- hdl/hms_ctrl.sv -----
// hms_ctrl: entry and run state of the timer, updated once per accepted item.
// Depends on hms_pkg.
module hms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  hms_pkg::req_type    req,
   output hms_pkg::status_type status_out
);
   import hms_pkg::*;

   typedef enum logic [1:0] {
      PH_HOUR = 2'd0,
      PH_MIN  = 2'd1,
      PH_SEC  = 2'd2,
      PH_RUN  = 2'd3
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [ACC_W-1:0] hour_acc_ff, hour_acc_in;
   logic [ACC_W-1:0] minute_acc_ff, minute_acc_in;
   logic [ACC_W-1:0] second_acc_ff, second_acc_in;
   logic [REM_W-1:0] remaining_ff, remaining_in;
   logic [REM_W-1:0] reload_ff, reload_in;
   logic             running_ff, running_in;
   logic             paused_ff, paused_in;
   logic             expired_ff, expired_in;

   logic             is_digit;
   logic [3:0]       digit;

   // acc * 10 + digit, wrapping at the accumulator width
   function automatic logic [ACC_W-1:0] acc10(input logic [ACC_W-1:0] acc,
                                              input logic [3:0] d);
      acc10 = (acc << 3) + (acc << 1) + ACC_W'(d);
   endfunction

   assign is_digit = (req.key_code >= KEY_ZERO) && (req.key_code <= KEY_NINE);
   assign digit    = 4'(req.key_code - KEY_ZERO);

   // next state for the item at the input
   always_comb begin
      phase_in      = phase_ff;
      hour_acc_in   = hour_acc_ff;
      minute_acc_in = minute_acc_ff;
      second_acc_in = second_acc_ff;
      remaining_in  = remaining_ff;
      reload_in     = reload_ff;
      running_in    = running_ff;
      paused_in     = paused_ff;
      expired_in    = expired_ff;

      if (req.func == FUNC_TICK) begin
         if (phase_ff == PH_RUN && running_ff) begin
            if (remaining_ff == '0) begin
               running_in = 1'b0;
               expired_in = 1'b1;
            end else begin
               remaining_in = remaining_ff - 1'b1;
            end
         end
      end else if (phase_ff == PH_RUN) begin
         case (req.key_code)
            KEY_C: begin
               running_in = paused_ff;
               paused_in  = ~paused_ff;
            end
            KEY_ZERO: begin
               remaining_in = reload_ff;
               expired_in   = 1'b0;
               paused_in    = 1'b1;
               running_in   = 1'b0;
            end
            default: ;
         endcase
      end else if (is_digit) begin
         case (phase_ff)
            PH_HOUR: hour_acc_in   = acc10(hour_acc_ff, digit);
            PH_MIN:  minute_acc_in = acc10(minute_acc_ff, digit);
            default: second_acc_in = acc10(second_acc_ff, digit);
         endcase
      end else if (req.key_code == KEY_C) begin
         case (phase_ff)
            PH_HOUR: begin
               remaining_in = remaining_ff + REM_W'(hour_acc_ff) * SECS_PER_HOUR;
               phase_in     = PH_MIN;
            end
            PH_MIN: begin
               remaining_in = remaining_ff + REM_W'(minute_acc_ff) * SECS_PER_MIN;
               phase_in     = PH_SEC;
            end
            default: begin
               remaining_in = remaining_ff + REM_W'(second_acc_ff);
               reload_in    = remaining_ff + REM_W'(second_acc_ff);
               phase_in     = PH_RUN;
               running_in   = 1'b1;
            end
         endcase
      end else if (req.key_code == KEY_PLUS) begin
         phase_in   = PH_RUN;
         running_in = 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HOUR;
         hour_acc_ff   <= '0;
         minute_acc_ff <= '0;
         second_acc_ff <= '0;
         remaining_ff  <= '0;
         reload_ff     <= '0;
         running_ff    <= 1'b0;
         paused_ff     <= 1'b0;
         expired_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         hour_acc_ff   <= hour_acc_in;
         minute_acc_ff <= minute_acc_in;
         second_acc_ff <= second_acc_in;
         remaining_ff  <= remaining_in;
         reload_ff     <= reload_in;
         running_ff    <= running_in;
         paused_ff     <= paused_in;
         expired_ff    <= expired_in;
      end
   end

   assign status_out.remaining = remaining_in;
   assign status_out.phase     = phase_in;
   assign status_out.running   = running_in;
   assign status_out.paused    = paused_in;
   assign status_out.expired   = expired_in;

`ifndef SYNTHESIS
   // run flags stay clear until entry is over
   a_entry_flags: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_RUN) |-> (!running_ff && !paused_ff && !expired_ff))
      else $error("run flag set during entry");

   // a counting tick above zero takes exactly one second off
   a_tick_dec: assert property (@(posedge clock) disable iff (reset)
      (accept && req.func == FUNC_TICK && phase_ff == PH_RUN && running_ff
       && remaining_ff != '0)
      |=> (remaining_ff == $past(remaining_ff) - 1'b1))
      else $error("tick did not decrement");

   // state moves only on an accepted item
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(remaining_ff) && $stable(phase_ff) && $stable(reload_ff)))
      else $error("state changed without an item");
`endif

endmodule

// ----- hdl/hms_split.sv -----
// hms_split: five-stage pipeline that splits the remaining time into h/m/s
// by reciprocal multiplication, with the registered result stage.
// Depends on hms_pkg.
module hms_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  hms_pkg::status_type status_in,
   output logic                take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hms_pkg::rsp_type    rsp_data
);
   import hms_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   status_type        st1_ff, st2_ff, st3_ff, st4_ff;
   logic [HOUR_W-1:0] q2_ff, q3_ff, q4_ff;
   logic [HOUR_W-1:0] q2_in;
   logic [11:0]       r3_ff, r4_ff, r3_in;
   logic [5:0]        mn4_ff, mn4_in;
   logic [5:0]        sec_in;
   logic [48:0]       prod_h;
   logic [20:0]       prod_m;
   rsp_type           rsp_ff, rsp_in;

   // a stage takes new data when empty or when its content moves on
   assign rdy5 = ~v5_ff | ~rsp_stall;
   assign rdy4 = ~v4_ff | rdy5;
   assign rdy3 = ~v3_ff | rdy4;
   assign rdy2 = ~v2_ff | rdy3;
   assign rdy1 = ~v1_ff | rdy2;
   assign take = rdy1;

   // stage 1 -> 2: hours
   assign prod_h = 49'(st1_ff.remaining[REM_W-1:4]) * 49'(HOUR_RECIP);
   assign q2_in  = prod_h[48:32];

   // stage 2 -> 3: seconds within the hour
   assign r3_in = 12'(st2_ff.remaining - REM_W'(q2_ff) * SECS_PER_HOUR);

   // stage 3 -> 4: minutes
   assign prod_m = 21'(r3_ff[11:2]) * 21'(MIN_RECIP);
   assign mn4_in = prod_m[19:14];

   // stage 4 -> 5: seconds and result assembly
   assign sec_in = 6'(r4_ff - 12'(mn4_ff) * 12'(SECS_PER_MIN));

   always_comb begin
      rsp_in.remaining_seconds = st4_ff.remaining;
      rsp_in.hours             = q4_ff;
      rsp_in.minutes           = mn4_ff;
      rsp_in.seconds           = sec_in;
      rsp_in.phase_now         = st4_ff.phase;
      rsp_in.counting          = st4_ff.running;
      rsp_in.paused_led        = st4_ff.paused;
      rsp_in.expired_led       = st4_ff.expired;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= accept;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rdy1 && accept) st1_ff <= status_in;
      if (rdy2) begin
         st2_ff <= st1_ff;
         q2_ff  <= q2_in;
      end
      if (rdy3) begin
         st3_ff <= st2_ff;
         q3_ff  <= q2_ff;
         r3_ff  <= r3_in;
      end
      if (rdy4) begin
         st4_ff <= st3_ff;
         q4_ff  <= q3_ff;
         r4_ff  <= r3_ff;
         mn4_ff <= mn4_in;
      end
      if (rdy5) rsp_ff <= rsp_in;
   end

   assign rsp_valid = v5_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // split fields are in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ff.minutes < 6'd60 && rsp_ff.seconds < 6'd60))
      else $error("minutes or seconds out of range");

   // h/m/s add back up to the total
   a_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (REM_W'(rsp_ff.hours) * SECS_PER_HOUR
                     + REM_W'(rsp_ff.minutes) * SECS_PER_MIN
                     + REM_W'(rsp_ff.seconds) == rsp_ff.remaining_seconds))
      else $error("h/m/s do not match remaining seconds");

   // an accepted item always lands in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (accept && take) |=> v1_ff)
      else $error("accepted item lost at pipeline entry");
`endif

endmodule

// ----- hdl/hms_countdown_timer.sv -----
// hms_countdown_timer: top level of the h/m/s countdown timer.
// Depends on hms_pkg, hms_ctrl and hms_split.
//
//   channel   dir   handshake             payload
//   req_      in    req_valid/req_stall   req_data  (hms_pkg::req_type)
//   rsp_      out   rsp_valid/rsp_stall   rsp_data  (hms_pkg::rsp_type)
//
// One item per cycle while req_stall is low; each item's result passes through
// the five-stage h/m/s split (two reciprocal multiplies, each registered).
// Timer state updates at the accepting edge, so back-to-back items chain.
// req_stall rises only when all five pipeline stages hold items and rsp_stall
// is high. Synchronous reset clears state and empties the pipeline.
module hms_countdown_timer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hms_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hms_pkg::rsp_type rsp_data
);
   import hms_pkg::*;

   logic       take;
   logic       accept;
   status_type status;

   assign req_stall = ~take;
   assign accept    = req_valid & take;

   hms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .status_out (status)
   );

   hms_split u_split (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .status_in (status),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for hms_countdown_timer. Sends tick and key items,
// predicts every readout and compares it field by field.
// Depends on hms_pkg and the hms_countdown_timer RTL.
module tb_top;
   import hms_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;    // pipeline is 5 deep, plus slack
   localparam int MAX_LINES    = 100;

   typedef enum logic [1:0] {
      ENTER_HOURS,
      ENTER_MINUTES,
      ENTER_SECONDS,
      COUNTDOWN
   } timer_phase_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct  = 33;
   int recv_stall_pct = 67;
   int error_count    = 0;
   int cycle_count    = 0;

   rsp_type expected_readouts[$];
   rsp_type oldest;

   // bench copy of the timer state
   timer_phase_type  tmr_phase   = ENTER_HOURS;
   logic [ACC_W-1:0] hour_acc    = '0;
   logic [ACC_W-1:0] minute_acc  = '0;
   logic [ACC_W-1:0] second_acc  = '0;
   logic [REM_W-1:0] tmr_remaining = '0;
   logic [REM_W-1:0] tmr_reload  = '0;
   logic             tmr_running = 1'b0;
   logic             tmr_paused  = 1'b0;
   logic             tmr_expired = 1'b0;

   hms_countdown_timer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Apply one item to the bench state and return the readout it gives.
   function automatic rsp_type advance_timer(input req_type item);
      rsp_type readout;
      if (item.func == FUNC_TICK) begin
         if (tmr_phase == COUNTDOWN && tmr_running) begin
            if (tmr_remaining == 0) begin
               tmr_running = 1'b0;
               tmr_expired = 1'b1;
            end else begin
               tmr_remaining = REM_W'(tmr_remaining - 1);
            end
         end
      end else if (tmr_phase == COUNTDOWN) begin
         if (item.key_code == KEY_C) begin
            // pause toggle; after expiry the first press only sets paused
            tmr_running = tmr_paused;
            tmr_paused  = !tmr_paused;
         end else if (item.key_code == KEY_ZERO) begin
            tmr_remaining = tmr_reload;
            tmr_expired   = 1'b0;
            tmr_paused    = 1'b1;
            tmr_running   = 1'b0;
         end
      end else if (item.key_code >= KEY_ZERO && item.key_code <= KEY_NINE) begin
         // accumulators wrap at 16 bits
         case (tmr_phase)
            ENTER_HOURS:   hour_acc   = ACC_W'(hour_acc * 10 + (item.key_code - KEY_ZERO));
            ENTER_MINUTES: minute_acc = ACC_W'(minute_acc * 10 + (item.key_code - KEY_ZERO));
            default:       second_acc = ACC_W'(second_acc * 10 + (item.key_code - KEY_ZERO));
         endcase
      end else if (item.key_code == KEY_C) begin
         case (tmr_phase)
            ENTER_HOURS: begin
               tmr_remaining = tmr_remaining + hour_acc * SECS_PER_HOUR;
               tmr_phase     = ENTER_MINUTES;
            end
            ENTER_MINUTES: begin
               tmr_remaining = tmr_remaining + minute_acc * SECS_PER_MIN;
               tmr_phase     = ENTER_SECONDS;
            end
            default: begin
               tmr_remaining = tmr_remaining + second_acc;
               tmr_reload    = tmr_remaining;
               tmr_phase     = COUNTDOWN;
               tmr_running   = 1'b1;
            end
         endcase
      end else if (item.key_code == KEY_PLUS) begin
         // early end of entry, reload value kept
         tmr_phase   = COUNTDOWN;
         tmr_running = 1'b1;
      end

      readout.remaining_seconds = tmr_remaining;
      readout.hours             = HOUR_W'(tmr_remaining / SECS_PER_HOUR);
      readout.minutes           = 6'((tmr_remaining / SECS_PER_MIN) % 60);
      readout.seconds           = 6'(tmr_remaining % 60);
      readout.phase_now         = tmr_phase;
      readout.counting          = tmr_running;
      readout.paused_led        = tmr_paused;
      readout.expired_led       = tmr_expired;
      return readout;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_LINES)
         $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // Send one item, idling first at random, and record its readout once taken.
   task automatic send_event(input req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_readouts.push_back(advance_timer(item));
   endtask

   function automatic req_type key_item(input logic [7:0] code);
      req_type item;
      item.func     = FUNC_KEY;
      item.key_code = code;
      return item;
   endfunction

   // key code is don't-care on a tick, so it carries random bits
   function automatic req_type tick_item();
      req_type item;
      item.func     = FUNC_TICK;
      item.key_code = 8'($urandom_range(255));
      return item;
   endfunction

   task automatic send_digits(input string digits);
      for (int i = 0; i < digits.len(); i++)
         send_event(key_item(digits[i]));
   endtask

   // Entry: ignored items, 16-bit wrap of the hour field to its maximum,
   // minutes pushing the hour count past 16 bits, then early end with '+'.
   task automatic test_entry_sequence();
      send_event(tick_item());
      send_event(key_item(8'h00));
      send_event(key_item(8'hFF));
      send_digits("196607");
      send_event(key_item(KEY_C));
      send_digits("60");
      send_event(key_item(KEY_C));
      send_digits("5");
      send_event(key_item(KEY_PLUS));
   endtask

   // Run: countdown across an hour boundary, pause and resume, reload to the
   // kept zero value, expiry, pause toggle after expiry, and a second expiry.
   task automatic test_pause_reload_expiry();
      send_event(tick_item());
      send_event(key_item(KEY_C));
      send_event(key_item(KEY_C));
      send_event(key_item(KEY_ZERO));
      send_event(tick_item());
      send_event(key_item(KEY_C));
      send_event(tick_item());
      send_event(key_item(KEY_C));
      send_event(key_item(KEY_C));
      send_event(tick_item());
   endtask

   // Random run-phase traffic; only ticks, pause and reload keys are counted.
   task automatic test_random_events(input int effective_target, input int idle_pct,
                                     input int stall_pct);
      req_type item;
      int      effective;
      int      pick;
      effective      = 0;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      while (effective < effective_target) begin
         pick          = $urandom_range(99);
         item.func     = FUNC_KEY;
         item.key_code = 8'($urandom_range(255));
         if (pick < 50)
            item.func = FUNC_TICK;
         else if (pick < 65)
            item.key_code = KEY_C;
         else if (pick < 72)
            item.key_code = KEY_ZERO;
         if (item.func == FUNC_TICK || item.key_code == KEY_C || item.key_code == KEY_ZERO)
            effective++;
         send_event(item);
      end
   endtask

   // Result side stalls at random.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Compare each taken readout with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readouts.size() == 0) begin
            report_mismatch("readout with none pending",
                            32'(rsp_data.remaining_seconds), '0);
         end else begin
            oldest = expected_readouts.pop_front();
            check_field("remaining_seconds", 32'(rsp_data.remaining_seconds),
                        32'(oldest.remaining_seconds));
            check_field("hours", 32'(rsp_data.hours), 32'(oldest.hours));
            check_field("minutes", 32'(rsp_data.minutes), 32'(oldest.minutes));
            check_field("seconds", 32'(rsp_data.seconds), 32'(oldest.seconds));
            check_field("phase_now", 32'(rsp_data.phase_now), 32'(oldest.phase_now));
            check_field("counting", 32'(rsp_data.counting), 32'(oldest.counting));
            check_field("paused_led", 32'(rsp_data.paused_led), 32'(oldest.paused_led));
            check_field("expired_led", 32'(rsp_data.expired_led),
                        32'(oldest.expired_led));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_entry_sequence();
      test_pause_reload_expiry();
      test_random_events(343, 33, 67);
      test_random_events(343, 67, 33);
      test_random_events(343, 0, 0);
      req_valid <= 1'b0;

      // drain outstanding readouts, then watch for strays
      recv_stall_pct = 0;
      while (expected_readouts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
